// ===== design/rational_add_mul_reduce_unit_defines.svh =====
`ifndef RATIONAL_ADD_MUL_REDUCE_UNIT_DEFINES_SVH
`define RATIONAL_ADD_MUL_REDUCE_UNIT_DEFINES_SVH
// same-cycle implication, disabled in reset
`define RAMR_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");
// next-cycle implication, disabled in reset
`define RAMR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next cycle");
`endif

// ===== design/ramr_pkg.sv =====
`default_nettype none
package ramr_pkg;
   localparam int OPB   = 16;
   localparam int VAL_W = OPB - 1;
   localparam int NUM_W = 2 * OPB - 1;
   localparam int DEN_W = 2 * OPB - 2;
   localparam int SUB_W = NUM_W + 1;
   localparam int CNT_W = $clog2(NUM_W);

   localparam logic [2:0] OP_MAKE = 3'd0;
   localparam logic [2:0] OP_ADD  = 3'd1;
   localparam logic [2:0] OP_MUL  = 3'd2;
   localparam logic [2:0] OP_EQ   = 3'd3;
   localparam logic [2:0] OP_NE   = 3'd4;

   typedef enum logic [2:0] {
      R_IDLE, R_TWOS, R_ODDU, R_LOOP, R_DIVX, R_DIVY, R_DONE
   } red_state_type;

   typedef enum logic [3:0] {
      T_IDLE, T_GA, T_WA, T_GB, T_WB, T_DEC, T_M0, T_M1, T_M2, T_M3,
      T_GR, T_WR, T_OUT
   } top_state_type;
endpackage
`default_nettype wire

// ===== design/ramr_reduce.sv =====
`default_nettype none
module ramr_reduce (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [ramr_pkg::NUM_W-1:0]  x,
   input  logic [ramr_pkg::NUM_W-1:0]  y,
   output logic                        done,
   output logic [ramr_pkg::NUM_W-1:0]  qx,
   output logic [ramr_pkg::NUM_W-1:0]  qy
);
   import ramr_pkg::*;

   red_state_type state_ff, state_in;
   logic [NUM_W-1:0] x_ff, x_in, y_ff, y_in, u_ff, u_in, v_ff, v_in;
   logic [NUM_W-1:0] g_ff, g_in, rem_ff, rem_in, dvd_ff, dvd_in;
   logic [NUM_W-1:0] qx_ff, qx_in, qy_ff, qy_in;
   logic [CNT_W-1:0] k_ff, k_in, cnt_ff, cnt_in;
   logic [SUB_W-1:0] sub_a, sub_b;
   logic [SUB_W:0]   sub_d;
   logic             borrow, last;
   logic [NUM_W-1:0] rem_nx, dvd_nx;

   // the one shared subtractor, used for compare, gcd step and division
   always_comb begin
      if (state_ff == R_DIVX || state_ff == R_DIVY) begin
         sub_a = {rem_ff, dvd_ff[NUM_W-1]};
         sub_b = {1'b0, g_ff};
      end else begin
         sub_a = {1'b0, v_ff};
         sub_b = {1'b0, u_ff};
      end
      sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
      borrow = sub_d[SUB_W];
      rem_nx = borrow ? sub_a[NUM_W-1:0] : sub_d[NUM_W-1:0];
      dvd_nx = {dvd_ff[NUM_W-2:0], ~borrow};
      last   = (cnt_ff == CNT_W'(NUM_W - 1));
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         R_IDLE: if (start) state_in = (x == '0 || y == '0) ? R_DONE : R_TWOS;
         R_TWOS: if (u_ff[0] || v_ff[0]) state_in = R_ODDU;
         R_ODDU: if (u_ff[0]) state_in = R_LOOP;
         R_LOOP: if (v_ff == '0) state_in = R_DIVX;
         R_DIVX: if (last) state_in = R_DIVY;
         R_DIVY: if (last) state_in = R_DONE;
         R_DONE: state_in = R_IDLE;
         default: state_in = R_IDLE;
      endcase
   end

   always_comb begin
      x_in = x_ff; y_in = y_ff; u_in = u_ff; v_in = v_ff; g_in = g_ff;
      rem_in = rem_ff; dvd_in = dvd_ff; qx_in = qx_ff; qy_in = qy_ff;
      k_in = k_ff; cnt_in = cnt_ff;
      unique case (state_ff)
         R_IDLE: if (start) begin
            x_in = x; y_in = y; u_in = x; v_in = y; k_in = '0;
            qx_in = x; qy_in = y;
         end
         R_TWOS: if (!u_ff[0] && !v_ff[0]) begin
            u_in = u_ff >> 1; v_in = v_ff >> 1; k_in = k_ff + 1'b1;
         end
         R_ODDU: if (!u_ff[0]) u_in = u_ff >> 1;
         R_LOOP: begin
            if (v_ff == '0) begin
               g_in = u_ff << k_ff; rem_in = '0; dvd_in = x_ff; cnt_in = '0;
            end else if (!v_ff[0]) begin
               v_in = v_ff >> 1;
            end else if (borrow) begin
               u_in = v_ff; v_in = u_ff;
            end else begin
               v_in = sub_d[NUM_W-1:0];
            end
         end
         R_DIVX: begin
            rem_in = rem_nx; dvd_in = dvd_nx; cnt_in = cnt_ff + 1'b1;
            if (last) begin
               qx_in = dvd_nx; rem_in = '0; dvd_in = y_ff; cnt_in = '0;
            end
         end
         R_DIVY: begin
            rem_in = rem_nx; dvd_in = dvd_nx; cnt_in = cnt_ff + 1'b1;
            if (last) qy_in = dvd_nx;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= R_IDLE;
      else       state_ff <= state_in;
      x_ff <= x_in; y_ff <= y_in; u_ff <= u_in; v_ff <= v_in; g_ff <= g_in;
      rem_ff <= rem_in; dvd_ff <= dvd_in; qx_ff <= qx_in; qy_ff <= qy_in;
      k_ff <= k_in; cnt_ff <= cnt_in;
   end

   assign done = (state_ff == R_DONE);
   assign qx   = qx_ff;
   assign qy   = qy_ff;
endmodule
`default_nettype wire

// ===== design/rational_add_mul_reduce_unit.sv =====
// channel  | handshake            | payload
// req      | req_valid/req_ready  | req_type, req_a_num, req_a_den, req_b_num, req_b_den
// rsp      | rsp_valid/rsp_ready  | rsp_res_num, rsp_res_den, rsp_res_flag
// one beat in flight at a time; req_ready is high only while idle
// each reduction runs a binary gcd on the two parts, then two 31-step restoring
// divisions on one shared subtractor; a reduction with a zero part skips both and
// passes its parts straight through; an item takes two reductions, plus the four
// multiply states T_M0 to T_M3 and a third reduction for add and mul on non-empty
// operands; synchronous reset returns both sequencers to idle; a held rsp beat
// stalls the block
`default_nettype none
`include "rational_add_mul_reduce_unit_defines.svh"
module rational_add_mul_reduce_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [2:0]                         req_type,
   input  logic signed [ramr_pkg::OPB-1:0]    req_a_num,
   input  logic signed [ramr_pkg::OPB-1:0]    req_a_den,
   input  logic signed [ramr_pkg::OPB-1:0]    req_b_num,
   input  logic signed [ramr_pkg::OPB-1:0]    req_b_den,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [ramr_pkg::NUM_W-1:0]         rsp_res_num,
   output logic [ramr_pkg::DEN_W-1:0]         rsp_res_den,
   output logic                               rsp_res_flag
);
   import ramr_pkg::*;

   top_state_type state_ff, state_in;
   logic [2:0]       op_ff, op_in;
   logic [OPB-1:0]   an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;
   logic [VAL_W-1:0] fan_ff, fan_in, fad_ff, fad_in, fbn_ff, fbn_in, fbd_ff, fbd_in;
   logic [NUM_W-1:0] rn_ff, rn_in;
   logic [DEN_W-1:0] rd_ff, rd_in, prod_ff, prod_in;
   logic             flag_ff, flag_in;
   logic             red_start, red_done, a_neg, b_neg, both, same, arith;
   logic [NUM_W-1:0] red_x, red_y, red_qx, red_qy;
   logic [VAL_W-1:0] mul_a, mul_b;

   ramr_reduce u_reduce (
      .clock (clock), .reset (reset), .start (red_start),
      .x (red_x), .y (red_y), .done (red_done), .qx (red_qx), .qy (red_qy)
   );

   always_comb begin
      a_neg = an_ff[OPB-1] | ad_ff[OPB-1];
      b_neg = bn_ff[OPB-1] | bd_ff[OPB-1];
      both  = !(fan_ff == '0 && fad_ff == '0) && !(fbn_ff == '0 && fbd_ff == '0);
      same  = (fan_ff == fbn_ff) && (fad_ff == fbd_ff);
      arith = (op_ff == OP_ADD || op_ff == OP_MUL) && both;
      red_start = (state_ff == T_GA) || (state_ff == T_GB) || (state_ff == T_GR);
      // negative parts form an empty fraction, which the reducer passes through
      red_x = '0;
      red_y = '0;
      if (state_ff == T_GA && !a_neg) begin
         red_x = NUM_W'(an_ff[VAL_W-1:0]);
         red_y = NUM_W'(ad_ff[VAL_W-1:0]);
      end else if (state_ff == T_GB && !b_neg) begin
         red_x = NUM_W'(bn_ff[VAL_W-1:0]);
         red_y = NUM_W'(bd_ff[VAL_W-1:0]);
      end else if (state_ff == T_GR) begin
         red_x = rn_ff;
         red_y = NUM_W'(rd_ff);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         T_IDLE: if (req_valid) state_in = T_GA;
         T_GA:   state_in = T_WA;
         T_WA:   if (red_done) state_in = T_GB;
         T_GB:   state_in = T_WB;
         T_WB:   if (red_done) state_in = T_DEC;
         T_DEC:  state_in = arith ? T_M0 : T_OUT;
         T_M0:   state_in = T_M1;
         T_M1:   state_in = T_M2;
         T_M2:   state_in = T_M3;
         T_M3:   state_in = T_GR;
         T_GR:   state_in = T_WR;
         T_WR:   if (red_done) state_in = T_OUT;
         T_OUT:  if (rsp_ready) state_in = T_IDLE;
         default: state_in = T_IDLE;
      endcase
   end

   always_comb begin
      op_in = op_ff; an_in = an_ff; ad_in = ad_ff; bn_in = bn_ff; bd_in = bd_ff;
      fan_in = fan_ff; fad_in = fad_ff; fbn_in = fbn_ff; fbd_in = fbd_ff;
      rn_in = rn_ff; rd_in = rd_ff; flag_in = flag_ff; prod_in = prod_ff;
      mul_a = fad_ff;
      mul_b = fbd_ff;
      unique case (state_ff)
         T_M0: begin
            mul_a = fan_ff;
            mul_b = (op_ff == OP_MUL) ? fbn_ff : fbd_ff;
         end
         T_M1: mul_b = fbn_ff;
         default: ;
      endcase
      unique case (state_ff)
         T_IDLE: if (req_valid) begin
            op_in = req_type; an_in = req_a_num; ad_in = req_a_den;
            bn_in = req_b_num; bd_in = req_b_den;
         end
         T_WA: if (red_done) begin
            fan_in = red_qx[VAL_W-1:0]; fad_in = red_qy[VAL_W-1:0];
         end
         T_WB: if (red_done) begin
            fbn_in = red_qx[VAL_W-1:0]; fbd_in = red_qy[VAL_W-1:0];
         end
         T_DEC: begin
            rn_in = '0; rd_in = '0; flag_in = 1'b0;
            case (op_ff)
               OP_MAKE: begin
                  rn_in = NUM_W'(fan_ff); rd_in = DEN_W'(fad_ff);
               end
               OP_EQ:   flag_in = both && same;
               OP_NE:   flag_in = both && !same;
               default: ;
            endcase
         end
         T_M0: prod_in = DEN_W'(mul_a * mul_b);
         T_M1: begin
            rn_in = NUM_W'(prod_ff);
            prod_in = DEN_W'(mul_a * mul_b);
         end
         T_M2: begin
            if (op_ff == OP_ADD) rn_in = rn_ff + NUM_W'(prod_ff);
            prod_in = DEN_W'(mul_a * mul_b);
         end
         T_M3: rd_in = prod_ff;
         T_WR: if (red_done) begin
            rn_in = red_qx; rd_in = red_qy[DEN_W-1:0];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= T_IDLE;
      else       state_ff <= state_in;
      op_ff <= op_in; an_ff <= an_in; ad_ff <= ad_in; bn_ff <= bn_in; bd_ff <= bd_in;
      fan_ff <= fan_in; fad_ff <= fad_in; fbn_ff <= fbn_in; fbd_ff <= fbd_in;
      rn_ff <= rn_in; rd_ff <= rd_in; flag_ff <= flag_in; prod_ff <= prod_in;
   end

   assign req_ready    = (state_ff == T_IDLE);
   assign rsp_valid    = (state_ff == T_OUT);
   assign rsp_res_num  = rn_ff;
   assign rsp_res_den  = rd_ff;
   assign rsp_res_flag = flag_ff;

   `RAMR_ASSERT_IMPL(a_one_in_flight, clock, reset, req_ready, !rsp_valid)
   `RAMR_ASSERT_IMPL(a_flag_no_parts, clock, reset, rsp_valid && rsp_res_flag,
                     rsp_res_num == '0 && rsp_res_den == '0)
   `RAMR_ASSERT_NEXT(a_accept_starts, clock, reset, req_valid && req_ready,
                     state_ff == T_GA)
endmodule
`default_nettype wire

// ===== tb/tb_rational_add_mul_reduce_unit.sv =====
`default_nettype none
module tb_rational_add_mul_reduce_unit;
   import ramr_pkg::*;

   localparam logic [2:0] OP_SPARE5 = 3'd5;
   localparam logic [2:0] OP_SPARE6 = 3'd6;
   localparam logic [2:0] OP_SPARE7 = 3'd7;
   localparam int         RANDOM_ITEMS = 650;
   localparam int         CYCLE_LIMIT  = 1_500_000;
   localparam int         DRAIN_CYCLES = 500;

   typedef struct packed {
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
      logic             flag;
   } frac_result_t;

   typedef struct {
      logic [2:0]     op;
      logic [OPB-1:0] an, ad, bn, bd;
      bit             typed;
      frac_result_t   res;
   } vector_t;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [2:0]          req_type = OP_MAKE;
   logic [OPB-1:0]      req_a_num = '0, req_a_den = '0, req_b_num = '0, req_b_den = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [NUM_W-1:0]    rsp_res_num;
   logic [DEN_W-1:0]    rsp_res_den;
   logic                rsp_res_flag;

   frac_result_t        pending_results[$];
   int                  mismatches = 0;
   int                  cycle_count = 0;
   int                  send_idle_pct = 0;
   int                  stall_pct = 0;

   rational_add_mul_reduce_unit dut (.*);

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(negedge clock)
      rsp_ready <= ($urandom_range(99) >= stall_pct);

   function automatic longint unsigned gcd_or_one(longint unsigned x, longint unsigned y);
      longint unsigned t;
      if (x == 0 || y == 0) return 1;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   function automatic void to_lowest(inout longint unsigned n, inout longint unsigned d);
      longint unsigned g;
      g = gcd_or_one(n, d);
      n = n / g;
      d = d / g;
   endfunction

   // negative part gives the empty fraction 0/0
   function automatic void form_frac(input logic [OPB-1:0] num, input logic [OPB-1:0] den,
                                     output longint unsigned n, output longint unsigned d);
      if (num[OPB-1] || den[OPB-1]) begin
         n = 0;
         d = 0;
      end else begin
         n = num;
         d = den;
         to_lowest(n, d);
      end
   endfunction

   function automatic frac_result_t rational_result(logic [2:0] op, logic [OPB-1:0] an,
                                                    logic [OPB-1:0] ad, logic [OPB-1:0] bn,
                                                    logic [OPB-1:0] bd);
      longint unsigned fan, fad, fbn, fbd, rn, rd;
      bit both, same;
      frac_result_t r;
      form_frac(an, ad, fan, fad);
      form_frac(bn, bd, fbn, fbd);
      both = !(fan == 0 && fad == 0) && !(fbn == 0 && fbd == 0);
      same = (fan == fbn) && (fad == fbd);
      rn = 0;
      rd = 0;
      r = '0;
      case (op)
         OP_MAKE: begin
            rn = fan;
            rd = fad;
         end
         OP_ADD: if (both) begin
            rn = fan * fbd + fad * fbn;
            rd = fad * fbd;
            to_lowest(rn, rd);
         end
         OP_MUL: if (both) begin
            rn = fan * fbn;
            rd = fad * fbd;
            to_lowest(rn, rd);
         end
         OP_EQ: r.flag = both && same;
         OP_NE: r.flag = both && !same;
         default: ;
      endcase
      r.num = rn[NUM_W-1:0];
      r.den = rd[DEN_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      frac_result_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected beat: num %0d den %0d flag %0d",
                        rsp_res_num, rsp_res_den, rsp_res_flag);
         end else begin
            want = pending_results.pop_front();
            if (rsp_res_num !== want.num || rsp_res_den !== want.den ||
                rsp_res_flag !== want.flag) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %0d/%0d flag %0d, got %0d/%0d flag %0d",
                           want.num, want.den, want.flag,
                           rsp_res_num, rsp_res_den, rsp_res_flag);
            end
         end
      end
   end

   // called at a falling edge, returns at a falling edge
   task automatic send_beat(vector_t v);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type  <= v.op;
      req_a_num <= v.an;
      req_a_den <= v.ad;
      req_b_num <= v.bn;
      req_b_den <= v.bd;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(v.typed ? v.res
                                        : rational_result(v.op, v.an, v.ad, v.bn, v.bd));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   function automatic logic [OPB-1:0] rand_part();
      int sel;
      sel = $urandom_range(99);
      if (sel < 12) return OPB'($urandom);            // any value, negatives included
      if (sel < 20) return {1'b0, {(OPB-1){1'b1}}} - OPB'($urandom_range(3));
      if (sel < 28) return OPB'($urandom_range(1));
      if (sel < 60) return OPB'($urandom_range(40));
      return {1'b0, VAL_W'($urandom)};
   endfunction

   function automatic vector_t row(logic [2:0] op, int an, int ad, int bn, int bd,
                                   bit typed = 0, longint n = 0, longint d = 0, bit f = 0);
      vector_t v;
      v.op = op;
      v.an = an[OPB-1:0];
      v.ad = ad[OPB-1:0];
      v.bn = bn[OPB-1:0];
      v.bd = bd[OPB-1:0];
      v.typed = typed;
      v.res.num = n[NUM_W-1:0];
      v.res.den = d[DEN_W-1:0];
      v.res.flag = f;
      return v;
   endfunction

   initial begin
      vector_t directed[$];
      vector_t v;
      int phase;

      directed.push_back(row(OP_MAKE, 6, 4, 0, 0, 1, 3, 2));
      directed.push_back(row(OP_MAKE, -1, 5, 1, 1, 1, 0, 0));
      directed.push_back(row(OP_MAKE, -32768, -1, 1, 1, 1, 0, 0));
      directed.push_back(row(OP_MAKE, 0, 5, 0, 0, 1, 0, 5));
      directed.push_back(row(OP_MAKE, 7, 0, 0, 0, 1, 7, 0));
      directed.push_back(row(OP_MAKE, 0, 0, 0, 0, 1, 0, 0));
      directed.push_back(row(OP_MAKE, 32767, 32767, -1, -1, 1, 1, 1));
      directed.push_back(row(OP_ADD, 1, 0, 1, 0, 1, 0, 0));     // zero-denominator sum
      directed.push_back(row(OP_ADD, 32767, 1, 32767, 1, 1, 65534, 1));
      directed.push_back(row(OP_ADD, 1, 32767, 1, 32767, 1, 2, 32767));
      directed.push_back(row(OP_ADD, 1, 2, -3, 4, 1, 0, 0));
      directed.push_back(row(OP_ADD, 1, 3, 1, 6));
      directed.push_back(row(OP_MUL, 32767, 1, 32767, 1, 1, 1073676289, 1));
      directed.push_back(row(OP_MUL, 1, 32767, 1, 32767, 1, 1, 1073676289));
      directed.push_back(row(OP_MUL, 0, 3, 5, 7, 1, 0, 21));
      directed.push_back(row(OP_MUL, 0, 0, 5, 7, 1, 0, 0));
      directed.push_back(row(OP_EQ, 2, 4, 1, 2, 1, 0, 0, 1));
      directed.push_back(row(OP_NE, 2, 4, 1, 2, 1, 0, 0, 0));
      directed.push_back(row(OP_NE, 2, 4, 1, 3, 1, 0, 0, 1));
      directed.push_back(row(OP_EQ, 0, 0, 0, 0, 1, 0, 0, 0));
      directed.push_back(row(OP_NE, 1, 2, -1, 2, 1, 0, 0, 0));
      directed.push_back(row(OP_SPARE5, 3, 4, 5, 6, 1, 0, 0, 0));
      directed.push_back(row(OP_SPARE6, 3, 4, 5, 6, 1, 0, 0, 0));
      directed.push_back(row(OP_SPARE7, 3, 4, 5, 6, 1, 0, 0, 0));

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i]) send_beat(directed[i]);
      wait_drained();   // sender holds off until every beat has come back

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         phase = i / (RANDOM_ITEMS / 4);
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 65; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 65; end
            default: begin send_idle_pct = 28; stall_pct = 28; end
         endcase
         v.op = ($urandom_range(15) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
         v.an = rand_part();
         v.ad = rand_part();
         if (v.op inside {OP_EQ, OP_NE} && $urandom_range(1)) begin
            // scaled copy so equal fractions turn up often
            v.bn = v.an * 2;
            v.bd = v.ad * 2;
         end else begin
            v.bn = rand_part();
            v.bd = rand_part();
         end
         v.typed = 0;
         send_beat(v);
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule
`default_nettype wire

// ===== rational_add_mul_reduce_unit.f =====
+incdir+design
design/ramr_pkg.sv
design/ramr_reduce.sv
design/rational_add_mul_reduce_unit.sv
tb/tb_rational_add_mul_reduce_unit.sv
